/* src/rbd_pkg.sv */
// Shared constants, op codes and status type for the retry backoff decision core.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package rbd_pkg;

	localparam int unsigned MAX_ITERATIONS_DEF = 15;

	// status codes
	localparam logic [9:0] ST_400 = 10'd400;
	localparam logic [9:0] ST_408 = 10'd408;
	localparam logic [9:0] ST_429 = 10'd429;
	localparam logic [9:0] ST_500 = 10'd500;
	localparam logic [9:0] ST_502 = 10'd502;
	localparam logic [9:0] ST_503 = 10'd503;
	localparam logic [9:0] ST_504 = 10'd504;

	// network error classes
	localparam logic [1:0] NET_NONE       = 2'd0;
	localparam logic [1:0] NET_NO_NETWORK = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_RETRY_EN  = 2'd0;
	localparam logic [1:0] REG_BASE      = 2'd1;
	localparam logic [1:0] REG_WINDOW    = 2'd2;
	localparam logic [1:0] REG_CACHE_EN  = 2'd3;

	localparam logic [12:0] POW_SAT     = 13'd4096;
	localparam logic [22:0] CAP_MS      = 23'd60000;
	localparam logic [31:0] MIN_500_MS  = 32'd10000;
	localparam logic [34:0] MIN_LEFT_MS = 35'd5000;
	localparam logic [13:0] JITTER_MAX  = 14'd9999;
	localparam logic [13:0] MS_PER_S    = 14'd1000;
	localparam logic [31:0] TW_MAX_MS   = 32'd65535000;

	// shared multiplier and constant divider
	localparam int unsigned MUL_A_W   = 31;
	localparam int unsigned MUL_B_W   = 14;
	localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
	localparam int unsigned DIV_BITS  = 4;
	localparam int unsigned DIV_STEPS = 12;
	localparam int unsigned NUM_W     = DIV_BITS * DIV_STEPS;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
	localparam logic [6:0] DIV_BY_10  = 7'd10;
	localparam logic [6:0] DIV_BY_50  = 7'd50;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_LOAD  = 4'd1;
	localparam op_t OP_POW   = 4'd2;
	localparam op_t OP_DIFF  = 4'd3;
	localparam op_t OP_MULJ  = 4'd4;
	localparam op_t OP_DIV10 = 4'd5;
	localparam op_t OP_WAIT  = 4'd6;
	localparam op_t OP_RA1   = 4'd7;
	localparam op_t OP_RAJ   = 4'd8;
	localparam op_t OP_DIV50 = 4'd9;
	localparam op_t OP_RASUM = 4'd10;
	localparam op_t OP_FIN   = 4'd11;
	localparam op_t OP_DEC   = 4'd12;
	localparam op_t OP_SKIP  = 4'd13;

	typedef struct packed {
		logic skip;
		logic pow_last;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/retry_backoff_decision_core.sv */
// Top level of the retry backoff decision core: sequencer plus datapath.
// Depends on rbd_pkg, rbd_ctrl and rbd_dpath.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------------------
//  item     | start / busy                 | status_code net_error iteration elapsed_ms
//           |                              | jitter retry_after_valid retry_after_s
//  result   | done (one-cycle strobe)      | retry delay_ms cache_write cache_pending
//  config   | cfg_valid / cfg_ready        | cfg_index cfg_data
//
// An item is taken when start is high and busy is low. Items that are skipped (retry
// disabled, no network or a status that is not retryable) strobe done after the check;
// the others run the power loop over n, the saturated iteration count, then two divides.
// A new item can be taken in the cycle that done is high. Results hold until the next
// result. cfg_ready is always high. arst_n restores the sequencer and config register reset values.
`default_nettype none

module retry_backoff_decision_core #(
	parameter int unsigned MAX_ITERATIONS = rbd_pkg::MAX_ITERATIONS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [9:0]  status_code,
	input  wire logic [1:0]  net_error,
	input  wire logic [3:0]  iteration,
	input  wire logic [31:0] elapsed_ms,
	input  wire logic [13:0] jitter,
	input  wire logic        retry_after_valid,
	input  wire logic [30:0] retry_after_s,
	output logic             done,
	output logic             retry,
	output logic [31:0]      delay_ms,
	output logic             cache_write,
	output logic             cache_pending,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	rbd_pkg::op_t        op;
	rbd_pkg::dp_status_t stat;

	assign cfg_ready = 1'b1;

	rbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	rbd_dpath #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.stat              (stat),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.status_code       (status_code),
		.net_error         (net_error),
		.iteration         (iteration),
		.elapsed_ms        (elapsed_ms),
		.jitter            (jitter),
		.retry_after_valid (retry_after_valid),
		.retry_after_s     (retry_after_s),
		.retry             (retry),
		.delay_ms          (delay_ms),
		.cache_write       (cache_write),
		.cache_pending     (cache_pending)
	);

endmodule

`default_nettype wire

/* src/rbd_ctrl.sv */
// Sequencer for the retry backoff decision core: steps the datapath through its ops.
// Depends on rbd_pkg.
`default_nettype none

module rbd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire rbd_pkg::dp_status_t stat,
	output rbd_pkg::op_t             op,
	output logic                     busy,
	output logic                     done
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_POW   = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_MULJ  = 4'd4;
	localparam logic [3:0] S_DIV10 = 4'd5;
	localparam logic [3:0] S_WAIT  = 4'd6;
	localparam logic [3:0] S_RA1   = 4'd7;
	localparam logic [3:0] S_RAJ   = 4'd8;
	localparam logic [3:0] S_DIV50 = 4'd9;
	localparam logic [3:0] S_RASUM = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_DEC   = 4'd12;
	localparam logic [3:0] S_SKIP  = 4'd13;

	localparam logic [rbd_pkg::DCNT_W-1:0] DCNT_LAST = rbd_pkg::DCNT_W'(rbd_pkg::DIV_STEPS - 1);

	logic [3:0]                  state_q, state_d;
	logic [rbd_pkg::DCNT_W-1:0]  dcnt_q;
	logic                        done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		state_d = state_q;
		op      = rbd_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = rbd_pkg::OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = stat.skip ? S_SKIP : S_POW;
			end
			S_POW: begin
				op = rbd_pkg::OP_POW;
				if (stat.pow_last) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				op      = rbd_pkg::OP_DIFF;
				state_d = S_MULJ;
			end
			S_MULJ: begin
				op      = rbd_pkg::OP_MULJ;
				state_d = S_DIV10;
			end
			S_DIV10: begin
				op = rbd_pkg::OP_DIV10;
				if (dcnt_q == DCNT_LAST) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				op      = rbd_pkg::OP_WAIT;
				state_d = S_RA1;
			end
			S_RA1: begin
				op      = rbd_pkg::OP_RA1;
				state_d = S_RAJ;
			end
			S_RAJ: begin
				op      = rbd_pkg::OP_RAJ;
				state_d = S_DIV50;
			end
			S_DIV50: begin
				op = rbd_pkg::OP_DIV50;
				if (dcnt_q == DCNT_LAST) begin
					state_d = S_RASUM;
				end
			end
			S_RASUM: begin
				op      = rbd_pkg::OP_RASUM;
				state_d = S_FIN;
			end
			S_FIN: begin
				op      = rbd_pkg::OP_FIN;
				state_d = S_DEC;
			end
			S_DEC: begin
				op      = rbd_pkg::OP_DEC;
				state_d = S_IDLE;
			end
			S_SKIP: begin
				op      = rbd_pkg::OP_SKIP;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DEC) || (state_q == S_SKIP);
			if ((state_q == S_DIV10) || (state_q == S_DIV50)) begin
				dcnt_q <= dcnt_q + 1'b1;
			end else begin
				dcnt_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/rbd_dpath.sv */
// Datapath of the retry backoff decision core: config registers, shared multiplier,
// saturating power loop, radix-16 constant divider and the final decision. Depends on rbd_pkg.
`default_nettype none

module rbd_dpath #(
	parameter int unsigned MAX_ITERATIONS = rbd_pkg::MAX_ITERATIONS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbd_pkg::op_t        op,
	output rbd_pkg::dp_status_t      stat,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic [9:0]          status_code,
	input  wire logic [1:0]          net_error,
	input  wire logic [3:0]          iteration,
	input  wire logic [31:0]         elapsed_ms,
	input  wire logic [13:0]         jitter,
	input  wire logic                retry_after_valid,
	input  wire logic [30:0]         retry_after_s,
	output logic                     retry,
	output logic [31:0]              delay_ms,
	output logic                     cache_write,
	output logic                     cache_pending
);

	localparam int unsigned PW = rbd_pkg::PROD_W;
	localparam int unsigned NW = rbd_pkg::NUM_W;

	// config
	logic        retry_en_q;
	logic [5:0]  base_q;
	logic [15:0] window_q;
	logic        cache_en_q;

	// captured item
	logic [9:0]  status_q;
	logic [1:0]  net_q;
	logic [3:0]  n_q;
	logic [31:0] elapsed_q;
	logic [13:0] j_q;
	logic        ra_valid_q;
	logic [30:0] ra_s_q;

	// working registers
	logic [3:0]  cnt_q;
	logic [12:0] p_q;
	logic [12:0] pmin_q;
	logic [12:0] diff_q;
	logic [22:0] wait_q;
	logic [25:0] twms_q;
	logic [41:0] ra_q;
	logic [NW-1:0] num_q;
	logic [6:0]  rem_q;
	logic [31:0] dly_q;
	logic [34:0] left_q;

	// results
	logic        retry_q;
	logic [31:0] delay_q;
	logic        cw_q;

	logic [rbd_pkg::MUL_A_W-1:0] mul_a;
	logic [rbd_pkg::MUL_B_W-1:0] mul_b;
	logic [PW-1:0]               prod;
	logic [12:0]                 pow_next;
	logic [12:0]                 pmax;
	logic [6:0]                  div_d;
	logic [6:0]                  div_r;
	logic [NW-1:0]               div_n;
	logic [23:0]                 wait_sum;
	logic [41:0]                 ra_eff;
	logic [41:0]                 big;
	logic [31:0]                 big_sat;
	logic                        retryable;
	logic                        skip;

	always_comb begin
		retryable = (status_q == rbd_pkg::ST_408) || (status_q == rbd_pkg::ST_429) ||
			(status_q == rbd_pkg::ST_500) || (status_q == rbd_pkg::ST_502) ||
			(status_q == rbd_pkg::ST_503) || (status_q == rbd_pkg::ST_504) ||
			(net_q != rbd_pkg::NET_NONE);
		skip = !retry_en_q || (net_q == rbd_pkg::NET_NO_NETWORK) || !retryable;
	end

	assign stat.skip     = skip;
	assign stat.pow_last = (cnt_q == n_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			rbd_pkg::OP_POW: begin
				mul_a = rbd_pkg::MUL_A_W'(p_q);
				mul_b = rbd_pkg::MUL_B_W'(base_q);
			end
			rbd_pkg::OP_DIFF: begin
				mul_a = rbd_pkg::MUL_A_W'(pmin_q);
				mul_b = rbd_pkg::MS_PER_S;
			end
			rbd_pkg::OP_MULJ: begin
				mul_a = rbd_pkg::MUL_A_W'(diff_q);
				mul_b = j_q;
			end
			rbd_pkg::OP_WAIT: begin
				mul_a = rbd_pkg::MUL_A_W'(window_q);
				mul_b = rbd_pkg::MS_PER_S;
			end
			rbd_pkg::OP_RA1: begin
				mul_a = ra_s_q;
				mul_b = rbd_pkg::MS_PER_S;
			end
			rbd_pkg::OP_RAJ: begin
				mul_a = ra_s_q;
				mul_b = j_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = PW'(mul_a) * PW'(mul_b);
	assign pow_next = (prod > PW'(rbd_pkg::POW_SAT)) ? rbd_pkg::POW_SAT : prod[12:0];
	assign pmax     = (p_q < pmin_q) ? pmin_q : p_q;

	// four quotient bits per cycle
	always_comb begin
		div_d = (op == rbd_pkg::OP_DIV50) ? rbd_pkg::DIV_BY_50 : rbd_pkg::DIV_BY_10;
		div_r = rem_q;
		div_n = num_q;
		for (int i = 0; i < int'(rbd_pkg::DIV_BITS); i++) begin
			div_r = {div_r[5:0], div_n[NW-1]};
			div_n = {div_n[NW-2:0], 1'b0};
			if (div_r >= div_d) begin
				div_r    = div_r - div_d;
				div_n[0] = 1'b1;
			end
		end
	end

	always_comb begin
		wait_sum = 24'(wait_q) + 24'(num_q[22:0]);
		ra_eff   = ra_valid_q ? ra_q : '0;
		big      = (ra_eff > 42'(wait_q)) ? ra_eff : 42'(wait_q);
		big_sat  = (|big[41:32]) ? '1 : big[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_en_q <= 1'b1;
			base_q     <= 6'd2;
			window_q   <= 16'd20;
			cache_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbd_pkg::REG_RETRY_EN: retry_en_q <= cfg_data[0];
				rbd_pkg::REG_BASE:     base_q     <= cfg_data[5:0];
				rbd_pkg::REG_WINDOW:   window_q   <= cfg_data;
				rbd_pkg::REG_CACHE_EN: cache_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			rbd_pkg::OP_LOAD: begin
				status_q   <= status_code;
				net_q      <= net_error;
				n_q        <= (32'(iteration) > 32'(MAX_ITERATIONS)) ?
					4'(MAX_ITERATIONS) : iteration;
				elapsed_q  <= elapsed_ms;
				j_q        <= (jitter > rbd_pkg::JITTER_MAX) ? rbd_pkg::JITTER_MAX : jitter;
				ra_valid_q <= retry_after_valid;
				ra_s_q     <= retry_after_s;
				cnt_q      <= '0;
				p_q        <= 13'd1;
			end
			rbd_pkg::OP_POW: begin
				if (cnt_q == n_q) begin
					pmin_q <= p_q;
				end
				p_q   <= pow_next;
				cnt_q <= cnt_q + 1'b1;
			end
			rbd_pkg::OP_DIFF: begin
				diff_q <= pmax - pmin_q;
				wait_q <= prod[22:0];
			end
			rbd_pkg::OP_MULJ, rbd_pkg::OP_RAJ: begin
				num_q <= NW'(prod);
				rem_q <= '0;
			end
			rbd_pkg::OP_DIV10, rbd_pkg::OP_DIV50: begin
				num_q <= div_n;
				rem_q <= div_r;
			end
			rbd_pkg::OP_WAIT: begin
				wait_q <= (wait_sum > 24'(rbd_pkg::CAP_MS)) ? rbd_pkg::CAP_MS : wait_sum[22:0];
				twms_q <= prod[25:0];
			end
			rbd_pkg::OP_RA1: begin
				ra_q <= prod[41:0];
			end
			rbd_pkg::OP_RASUM: begin
				ra_q <= ra_q + num_q[41:0];
			end
			rbd_pkg::OP_FIN: begin
				dly_q  <= ((status_q == rbd_pkg::ST_500) && (big_sat < rbd_pkg::MIN_500_MS)) ?
					rbd_pkg::MIN_500_MS : big_sat;
				left_q <= 35'(twms_q) - 35'(elapsed_q) - rbd_pkg::MIN_LEFT_MS;
			end
			rbd_pkg::OP_DEC: begin
				// time left after the 5 s margin must be positive and cover the delay
				retry_q <= !left_q[34] && (left_q != '0) && (left_q[33:0] >= 34'(dly_q));
				delay_q <= dly_q;
				cw_q    <= cache_en_q && ra_valid_q && (status_q > rbd_pkg::ST_400);
			end
			rbd_pkg::OP_SKIP: begin
				retry_q <= 1'b0;
				delay_q <= '0;
				cw_q    <= 1'b0;
			end
			default: ;
		endcase
	end

	assign retry         = retry_q;
	assign delay_ms      = delay_q;
	assign cache_write   = cw_q;
	assign cache_pending = retry_q;

endmodule

`default_nettype wire

/* src/rbd_checker.sv */
// Port-level checks for the retry backoff decision core, bound to the top level.
// Depends on rbd_pkg.
`default_nettype none

module rbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        retry,
	input wire logic [31:0] delay_ms,
	input wire logic        cache_pending
);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding busy cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_pending_eq_retry: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cache_pending == retry))
		else $error("cache_pending differs from retry");

	a_retry_fits_window: assert property (@(posedge clk) disable iff (!arst_n)
		(done && retry) |-> (delay_ms <= rbd_pkg::TW_MAX_MS))
		else $error("retry granted with a delay beyond any timeout window");

endmodule

bind retry_backoff_decision_core rbd_checker u_rbd_checker (.*);

`default_nettype wire
